>>> rtl/core/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg
// Types, constants and helpers shared by the linear scan register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // Field widths
    localparam int VREG_W  = 8;
    localparam int POS_W   = 16;
    localparam int PHYS_W  = 3;
    localparam int ADDR_W  = 8;

    // Active list and register file
    localparam int ACT_DEPTH = 7;
    localparam int IDX_W     = $clog2(ACT_DEPTH);
    localparam int CNT_W     = $clog2(ACT_DEPTH + 1);
    localparam int NUM_PHYS  = 7;

    // Register classes: pointer intervals use the low pair, others the rest
    localparam logic [PHYS_W-1:0] IND_HI = 3'd1;

    localparam logic [ADDR_W-1:0] SPILL_BASE_RST = 8'h30;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic              indirect;
    } t_item;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic [POS_W-1:0]  end_pos;
        logic [PHYS_W-1:0] phys;
    } t_entry;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic              spilled;
        logic [PHYS_W-1:0] phys;
        logic              last;
    } t_result;

    // Controller to scan unit
    typedef struct packed {
        logic              clear;
        logic              accum;
        logic [IDX_W-1:0]  idx;
        logic              ind;
        logic [POS_W-1:0]  end_pos;
    } t_scan_ctl;

    // Scan unit to controller
    typedef struct packed {
        logic              free_ok;
        logic [PHYS_W-1:0] free_phys;
        logic              cand_ok;
        logic [IDX_W-1:0]  cand_idx;
        logic [VREG_W-1:0] cand_vreg;
        logic [PHYS_W-1:0] cand_phys;
    } t_scan_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EX,
        ST_SWAP,
        ST_DECIDE,
        ST_EVICT_RD,
        ST_EVICT_MV,
        ST_OUT_FIRST,
        ST_OUT_LAST
    } t_state;

    // True when a physical register belongs to the class of the interval
    function automatic logic in_class(input logic [PHYS_W-1:0] phys, input logic ind);
        in_class = ind ? (phys <= IND_HI) : (phys > IND_HI);
    endfunction

endpackage

>>> rtl/core/lsra_in_if.sv
// ----------------------------------------------------------------------------
// lsra_in_if
// Live interval channel: valid/ready with one interval per beat.
// ----------------------------------------------------------------------------
interface lsra_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsra_pkg::VREG_W-1:0]   vreg;
    logic [lsra_pkg::POS_W-1:0]    start_pos;
    logic [lsra_pkg::POS_W-1:0]    end_pos;
    logic                          indirect;

    modport source (output valid, vreg, start_pos, end_pos, indirect, input ready);
    modport sink   (input valid, vreg, start_pos, end_pos, indirect, output ready);
endinterface

>>> rtl/core/lsra_out_if.sv
// ----------------------------------------------------------------------------
// lsra_out_if
// Placement result channel: valid/ready with one decision per beat.
// ----------------------------------------------------------------------------
interface lsra_out_if;
    logic                          valid;
    logic                          ready;
    logic [lsra_pkg::VREG_W-1:0]   result_vreg;
    logic                          spilled;
    logic [lsra_pkg::PHYS_W-1:0]   phys_reg;
    logic [lsra_pkg::ADDR_W-1:0]   spill_address;
    logic                          last;

    modport source (output valid, result_vreg, spilled, phys_reg, spill_address, last,
                    input ready);
    modport sink   (input valid, result_vreg, spilled, phys_reg, spill_address, last,
                    output ready);
endinterface

>>> rtl/core/lsra_ram.sv
// ----------------------------------------------------------------------------
// lsra_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lsra_scan.sv
// ----------------------------------------------------------------------------
// lsra_scan
// Shared scan unit: gathers the used-register mask and the same-class
// eviction candidate while the active list is walked, then offers the
// lowest free register and the eviction verdict.
// ----------------------------------------------------------------------------
module lsra_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsra_pkg::t_scan_ctl   i_ctl,
    input  lsra_pkg::t_entry      i_cur,
    output lsra_pkg::t_scan_sts   o_sts
);

    logic [lsra_pkg::NUM_PHYS-1:0] r_mask, n_mask;
    logic                          r_cand_vld, n_cand_vld;
    logic [lsra_pkg::POS_W-1:0]    r_best, n_best;
    logic [lsra_pkg::IDX_W-1:0]    r_cand_idx, n_cand_idx;
    logic [lsra_pkg::VREG_W-1:0]   r_cand_vreg, n_cand_vreg;
    logic [lsra_pkg::PHYS_W-1:0]   r_cand_phys, n_cand_phys;
    logic                          free_ok;
    logic [lsra_pkg::PHYS_W-1:0]   free_phys;

    // Accumulate over the surviving entries, in list order
    always_comb begin
        n_mask      = r_mask;
        n_cand_vld  = r_cand_vld;
        n_best      = r_best;
        n_cand_idx  = r_cand_idx;
        n_cand_vreg = r_cand_vreg;
        n_cand_phys = r_cand_phys;
        if (i_ctl.clear) begin
            n_mask     = '0;
            n_cand_vld = 1'b0;
        end else if (i_ctl.accum) begin
            n_mask[i_cur.phys] = 1'b1;
            // strict greater keeps the earliest entry on ties
            if (lsra_pkg::in_class(i_cur.phys, i_ctl.ind) &&
                (!r_cand_vld || (i_cur.end_pos > r_best))) begin
                n_cand_vld  = 1'b1;
                n_best      = i_cur.end_pos;
                n_cand_idx  = i_ctl.idx;
                n_cand_vreg = i_cur.vreg;
                n_cand_phys = i_cur.phys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_cand_vld <= 1'b0;
        end else begin
            r_mask     <= n_mask;
            r_cand_vld <= n_cand_vld;
        end
        r_best      <= n_best;
        r_cand_idx  <= n_cand_idx;
        r_cand_vreg <= n_cand_vreg;
        r_cand_phys <= n_cand_phys;
    end

    // Lowest free register of the class: walk down so the lowest wins
    always_comb begin
        free_ok   = 1'b0;
        free_phys = '0;
        for (int r = lsra_pkg::NUM_PHYS - 1; r >= 0; r--) begin
            if (lsra_pkg::in_class(lsra_pkg::PHYS_W'(r), i_ctl.ind) && !r_mask[r]) begin
                free_ok   = 1'b1;
                free_phys = lsra_pkg::PHYS_W'(r);
            end
        end
    end

    assign o_sts.free_ok   = free_ok;
    assign o_sts.free_phys = free_phys;
    assign o_sts.cand_ok   = r_cand_vld && (r_best > i_ctl.end_pos);
    assign o_sts.cand_idx  = r_cand_idx;
    assign o_sts.cand_vreg = r_cand_vreg;
    assign o_sts.cand_phys = r_cand_phys;

endmodule

>>> rtl/core/lsra_ctrl.sv
// ----------------------------------------------------------------------------
// lsra_ctrl
// Sequencer: walks the active list in memory, expires stale entries by
// swap-with-last, then places, evicts or spills the new interval.
// ----------------------------------------------------------------------------
module lsra_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    input  lsra_pkg::t_item              i_item,
    output logic                         o_ram_we,
    output logic [lsra_pkg::IDX_W-1:0]   o_ram_waddr,
    output lsra_pkg::t_entry             o_ram_wdata,
    output logic [lsra_pkg::IDX_W-1:0]   o_ram_raddr,
    input  lsra_pkg::t_entry             i_ram_rdata,
    output lsra_pkg::t_scan_ctl          o_scan_ctl,
    input  lsra_pkg::t_scan_sts          i_scan_sts,
    output logic                         o_res_load,
    output lsra_pkg::t_result            o_res,
    input  logic                         i_res_taken
);

    lsra_pkg::t_state             r_state, n_state;
    logic [lsra_pkg::CNT_W-1:0]   r_count, n_count;
    logic [lsra_pkg::CNT_W-1:0]   r_idx, n_idx;
    lsra_pkg::t_item              r_item, n_item;
    logic [lsra_pkg::IDX_W-1:0]   last_idx;
    logic [lsra_pkg::IDX_W-1:0]   cur_idx;

    assign last_idx = lsra_pkg::IDX_W'(r_count - 1'b1);
    assign cur_idx  = lsra_pkg::IDX_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsra_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx  <= n_idx;
        r_item <= n_item;
    end

    // Next state and datapath controls
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_item       = r_item;
        o_item_ready = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = cur_idx;
        o_ram_wdata  = i_ram_rdata;
        o_ram_raddr  = '0;
        o_res_load   = 1'b0;
        o_res        = '0;

        o_scan_ctl.clear   = 1'b0;
        o_scan_ctl.accum   = 1'b0;
        o_scan_ctl.idx     = cur_idx;
        o_scan_ctl.ind     = r_item.indirect;
        o_scan_ctl.end_pos = r_item.end_pos;

        case (r_state)
            lsra_pkg::ST_IDLE: begin
                o_item_ready     = 1'b1;
                o_scan_ctl.clear = 1'b1;
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_idx   = '0;
                    n_state = lsra_pkg::ST_SCAN_RD;
                end
            end

            // Fetch entry at the walk index, or finish the walk
            lsra_pkg::ST_SCAN_RD: begin
                if (r_idx < r_count) begin
                    o_ram_raddr = cur_idx;
                    n_state     = lsra_pkg::ST_SCAN_EX;
                end else begin
                    n_state = lsra_pkg::ST_DECIDE;
                end
            end

            // Expired: fetch the last entry to fill the hole; else keep it
            lsra_pkg::ST_SCAN_EX: begin
                if (i_ram_rdata.end_pos < r_item.start_pos) begin
                    o_ram_raddr = last_idx;
                    n_state     = lsra_pkg::ST_SWAP;
                end else begin
                    o_scan_ctl.accum = 1'b1;
                    n_idx            = r_idx + 1'b1;
                    n_state          = lsra_pkg::ST_SCAN_RD;
                end
            end

            // Move last entry into the hole; same slot is looked at again
            lsra_pkg::ST_SWAP: begin
                o_ram_we = 1'b1;
                n_count  = r_count - 1'b1;
                n_state  = lsra_pkg::ST_SCAN_RD;
            end

            lsra_pkg::ST_DECIDE: begin
                if (i_scan_sts.free_ok && (r_count < lsra_pkg::CNT_W'(lsra_pkg::ACT_DEPTH))) begin
                    // append to the list
                    o_ram_we          = 1'b1;
                    o_ram_waddr       = lsra_pkg::IDX_W'(r_count);
                    o_ram_wdata.vreg  = r_item.vreg;
                    o_ram_wdata.end_pos = r_item.end_pos;
                    o_ram_wdata.phys  = i_scan_sts.free_phys;
                    n_count           = r_count + 1'b1;
                    o_res_load        = 1'b1;
                    o_res.vreg        = r_item.vreg;
                    o_res.phys        = i_scan_sts.free_phys;
                    o_res.last        = 1'b1;
                    n_state           = lsra_pkg::ST_OUT_LAST;
                end else if (i_scan_sts.cand_ok) begin
                    o_ram_raddr = last_idx;
                    n_state     = lsra_pkg::ST_EVICT_RD;
                end else begin
                    // the new interval goes to memory
                    o_res_load    = 1'b1;
                    o_res.vreg    = r_item.vreg;
                    o_res.spilled = 1'b1;
                    o_res.last    = 1'b1;
                    n_state       = lsra_pkg::ST_OUT_LAST;
                end
            end

            // Victim slot takes the last entry
            lsra_pkg::ST_EVICT_RD: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = i_scan_sts.cand_idx;
                n_state     = lsra_pkg::ST_EVICT_MV;
            end

            // Last slot takes the new interval in the victim's register
            lsra_pkg::ST_EVICT_MV: begin
                o_ram_we            = 1'b1;
                o_ram_waddr         = last_idx;
                o_ram_wdata.vreg    = r_item.vreg;
                o_ram_wdata.end_pos = r_item.end_pos;
                o_ram_wdata.phys    = i_scan_sts.cand_phys;
                o_res_load          = 1'b1;
                o_res.vreg          = i_scan_sts.cand_vreg;
                o_res.spilled       = 1'b1;
                n_state             = lsra_pkg::ST_OUT_FIRST;
            end

            lsra_pkg::ST_OUT_FIRST: begin
                if (i_res_taken) begin
                    o_res_load = 1'b1;
                    o_res.vreg = r_item.vreg;
                    o_res.phys = i_scan_sts.cand_phys;
                    o_res.last = 1'b1;
                    n_state    = lsra_pkg::ST_OUT_LAST;
                end
            end

            lsra_pkg::ST_OUT_LAST: begin
                if (i_res_taken) begin
                    n_state = lsra_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lsra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/linear_scan_register_allocator.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Places presorted live intervals into seven physical registers or spills
// them to memory, one interval at a time.
// ----------------------------------------------------------------------------
// One interval is taken per handshake and gives one result beat, or two when
// an active interval is evicted (victim first). The block holds ready low
// from the accepting beat until its last result beat has been taken. Work per
// interval is set by the active list, kept in a small memory with registered
// read and walked one entry at a time: the accepting step, a read and an
// examine step per surviving entry, a swap step as well for each expired
// entry, a read step that ends the walk, a decide step, an evict-read and an
// evict-move step to rewrite the list on an eviction, and a step per result
// beat; stalls on the output lengthen this.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lsra_in_if.sink                       i_in,
    lsra_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [lsra_pkg::ADDR_W-1:0]   i_cfg_wr_data
);

    logic [lsra_pkg::ADDR_W-1:0]   r_spill_base;
    logic                          r_out_valid;
    lsra_pkg::t_result             r_out;
    logic [lsra_pkg::ADDR_W-1:0]   r_out_addr;

    lsra_pkg::t_item               item;
    logic                          item_ready;
    logic                          ram_we;
    logic [lsra_pkg::IDX_W-1:0]    ram_waddr;
    logic [lsra_pkg::IDX_W-1:0]    ram_raddr;
    lsra_pkg::t_entry              ram_wdata;
    lsra_pkg::t_entry              ram_rdata;
    lsra_pkg::t_scan_ctl           scan_ctl;
    lsra_pkg::t_scan_sts           scan_sts;
    logic                          res_load;
    lsra_pkg::t_result             res;
    logic                          res_taken;

    // Spill base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spill_base <= lsra_pkg::SPILL_BASE_RST;
        end else if (i_cfg_wr_en) begin
            r_spill_base <= i_cfg_wr_data;
        end
    end

    assign item.vreg      = i_in.vreg;
    assign item.start_pos = i_in.start_pos;
    assign item.end_pos   = i_in.end_pos;
    assign item.indirect  = i_in.indirect;
    assign i_in.ready     = item_ready;

    lsra_ram #(
        .WIDTH ($bits(lsra_pkg::t_entry)),
        .DEPTH (lsra_pkg::ACT_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lsra_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_cur   (ram_rdata),
        .o_sts   (scan_sts)
    );

    lsra_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in.valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_scan_ctl   (scan_ctl),
        .i_scan_sts   (scan_sts),
        .o_res_load   (res_load),
        .o_res        (res),
        .i_res_taken  (res_taken)
    );

    assign res_taken = r_out_valid && o_out.ready;

    // Output register; a new load wins over the beat just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (res_taken) begin
            r_out_valid <= 1'b0;
        end
        if (res_load) begin
            r_out      <= res;
            r_out_addr <= res.spilled ? lsra_pkg::ADDR_W'(r_spill_base + res.vreg) : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_vreg   = r_out.vreg;
    assign o_out.spilled       = r_out.spilled;
    assign o_out.phys_reg      = r_out.phys;
    assign o_out.spill_address = r_out_addr;
    assign o_out.last          = r_out.last;

endmodule

>>> bench/linear_scan_register_allocator_checker.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_checker
// Watches the interval and placement channels, predicts each placement from
// its own copy of the active list and spill base, and compares every result
// beat field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_checker
    import lsra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    lsra_in_if                 i_in,
    lsra_out_if                i_out,
    input  logic               i_cfg_wr_en,
    input  logic [ADDR_W-1:0]  i_cfg_wr_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic              spilled;
        logic [PHYS_W-1:0] phys;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_placement;

    // Predicted placements, oldest first
    t_placement placement_q[$];

    // Shadow of the block's active list and spill base
    logic [VREG_W-1:0] live_vreg [ACT_DEPTH];
    logic [POS_W-1:0]  live_end  [ACT_DEPTH];
    logic [PHYS_W-1:0] live_phys [ACT_DEPTH];
    int                live_cnt;
    logic [ADDR_W-1:0] spill_base;
    int                fail_count;

    assign o_fail_count = fail_count;

    function automatic t_placement make_placement(input logic [VREG_W-1:0] v,
                                                  input logic spill,
                                                  input logic [PHYS_W-1:0] ph,
                                                  input logic fin);
        t_placement p;
        p.vreg    = v;
        p.spilled = spill;
        p.phys    = spill ? '0 : ph;
        p.addr    = spill ? ADDR_W'(spill_base + v) : '0;
        p.last    = fin;
        return p;
    endfunction

    // Predict the placements caused by one interval and update the active list
    task automatic allocate_interval(input logic [VREG_W-1:0] v,
                                     input logic [POS_W-1:0] s,
                                     input logic [POS_W-1:0] e,
                                     input logic ind);
        int                j;
        int                tail;
        int                cand;
        int                free_phys;
        int                lo;
        int                hi;
        bit                busy;
        logic [POS_W-1:0]  best;
        logic [PHYS_W-1:0] ph;

        // retire entries that ended before this start; the moved-in entry is
        // looked at again
        j = 0;
        while (j < live_cnt) begin
            if (live_end[j] < s) begin
                tail         = live_cnt - 1;
                live_vreg[j] = live_vreg[tail];
                live_end[j]  = live_end[tail];
                live_phys[j] = live_phys[tail];
                live_cnt--;
            end else begin
                j++;
            end
        end

        // lowest free register of the class
        lo        = ind ? 0 : int'(IND_HI) + 1;
        hi        = ind ? int'(IND_HI) : NUM_PHYS - 1;
        free_phys = -1;
        for (int r = lo; r <= hi && free_phys < 0; r++) begin
            busy = 1'b0;
            for (int k = 0; k < live_cnt; k++)
                if (int'(live_phys[k]) == r) busy = 1'b1;
            if (!busy) free_phys = r;
        end

        if (free_phys >= 0 && live_cnt < ACT_DEPTH) begin
            live_vreg[live_cnt] = v;
            live_end[live_cnt]  = e;
            live_phys[live_cnt] = PHYS_W'(free_phys);
            live_cnt++;
            placement_q.push_back(make_placement(v, 1'b0, PHYS_W'(free_phys), 1'b1));
        end else begin
            // same-class entry with the greatest end, earliest on ties
            cand = -1;
            best = '0;
            for (j = 0; j < live_cnt; j++) begin
                if ((live_phys[j] <= IND_HI) == ind) begin
                    if (cand < 0 || live_end[j] > best) begin
                        best = live_end[j];
                        cand = j;
                    end
                end
            end
            if (cand >= 0 && best > e) begin
                // evict: victim beat first, then the newcomer takes its register
                ph   = live_phys[cand];
                tail = live_cnt - 1;
                placement_q.push_back(make_placement(live_vreg[cand], 1'b1, '0, 1'b0));
                live_vreg[cand] = live_vreg[tail];
                live_end[cand]  = live_end[tail];
                live_phys[cand] = live_phys[tail];
                live_vreg[tail] = v;
                live_end[tail]  = e;
                live_phys[tail] = ph;
                placement_q.push_back(make_placement(v, 1'b0, ph, 1'b1));
            end else begin
                placement_q.push_back(make_placement(v, 1'b1, '0, 1'b1));
            end
        end
    endtask

    // Sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        t_placement want;
        t_placement got;

        if (!i_rst_n) begin
            live_cnt   = 0;
            spill_base = SPILL_BASE_RST;
            fail_count = 0;
            placement_q.delete();
        end else begin
            if (i_cfg_wr_en)
                spill_base = i_cfg_wr_data;

            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                allocate_interval(i_in.vreg, i_in.start_pos, i_in.end_pos, i_in.indirect);

            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                got.vreg    = i_out.result_vreg;
                got.spilled = i_out.spilled;
                got.phys    = i_out.phys_reg;
                got.addr    = i_out.spill_address;
                got.last    = i_out.last;
                if (placement_q.size() == 0) begin
                    fail_count++;
                    $display({"%0t: unexpected result beat, expected none, got vreg=%0d",
                              " spilled=%0b phys=%0d addr=%0d last=%0b"},
                             $time, got.vreg, got.spilled, got.phys, got.addr, got.last);
                end else begin
                    want = placement_q.pop_front();
                    if (got.vreg !== want.vreg || got.spilled !== want.spilled ||
                        got.phys !== want.phys || got.addr !== want.addr ||
                        got.last !== want.last) begin
                        fail_count++;
                        $display({"%0t: mismatch expected vreg=%0d spilled=%0b phys=%0d",
                                  " addr=%0d last=%0b, got vreg=%0d spilled=%0b phys=%0d",
                                  " addr=%0d last=%0b"},
                                 $time, want.vreg, want.spilled, want.phys, want.addr,
                                 want.last, got.vreg, got.spilled, got.phys, got.addr,
                                 got.last);
                    end
                end
            end
        end
        o_pending <= placement_q.size();
    end

endmodule

>>> bench/linear_scan_register_allocator_test.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_test
// Drives live intervals into the allocator: a directed run over the edge
// cases, then random sorted programs mixed with noise under three idling
// patterns and a long output stall, with the spill base changed between
// phases. The checker alongside predicts and compares every result beat.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lsra_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                hold_reqs;

    lsra_in_if  in_ch ();
    lsra_out_if out_ch ();

    linear_scan_register_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    linear_scan_register_allocator_checker u_placement_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request
    initial begin
        int seen_holds;
        int hold_left;

        seen_holds = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != seen_holds) begin
                seen_holds = hold_reqs;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // One interval beat, with random gaps ahead of it
    task automatic place_interval(input logic [VREG_W-1:0] v, input logic [POS_W-1:0] s,
                                  input logic [POS_W-1:0] e, input logic ind);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.vreg      <= v;
        in_ch.start_pos <= s;
        in_ch.end_pos   <= e;
        in_ch.indirect  <= ind;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Wait for every predicted beat, then let the block settle
    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_spill_base(input logic [ADDR_W-1:0] base);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly sorted programs with random content; some unsorted noise
    task automatic run_random_intervals(input int n_items);
        int   pos;
        int   seg_left;
        int   span;
        int   prev_start;
        int   prev_end;
        int   s;
        int   e;
        int   pick;
        logic ind;

        pos        = 0;
        seg_left   = 0;
        prev_start = -1;
        prev_end   = 0;
        repeat (n_items) begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(10, 60);
                pos        = ($urandom_range(0, 9) == 0) ? $urandom_range(60000, 65535)
                                                         : $urandom_range(0, 2000);
                prev_start = -1;
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                pos += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (pos > 65535) pos = 65535;
                pick = $urandom_range(0, 99);
                if (pick < 50)      span = $urandom_range(0, 12);
                else if (pick < 80) span = $urandom_range(13, 120);
                else if (pick < 96) span = $urandom_range(121, 4000);
                else                span = $urandom_range(4001, 65535);
                s = pos;
                e = s + span;
                if (e > 65535) e = 65535;
                // same start: keep ends in ascending order
                if (s == prev_start && e < prev_end) e = prev_end;
                prev_start = s;
                prev_end   = e;
            end else begin
                s = $urandom_range(0, 65535);
                e = $urandom_range(0, 65535);
            end
            ind = ($urandom_range(0, 99) < 35);
            place_interval(VREG_W'($urandom_range(0, 255)), POS_W'(s), POS_W'(e), ind);
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.vreg      <= '0;
        in_ch.start_pos <= '0;
        in_ch.end_pos   <= '0;
        in_ch.indirect  <= 1'b0;
        hold_reqs       <= 0;
        rx_idle_pct     <= 84;
        tx_idle_pct      = 21;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pointer pair fills, eviction with wrapped address, self spill
        place_interval(8'd0,   16'd0, 16'd10,    1'b1);
        place_interval(8'd255, 16'd0, 16'd20,    1'b1);
        place_interval(8'd5,   16'd1, 16'd5,     1'b1);
        place_interval(8'd6,   16'd2, 16'd65535, 1'b1);
        // general registers fill up, tie on greatest end, then self spill
        place_interval(8'd10,  16'd3, 16'd100,   1'b0);
        place_interval(8'd11,  16'd3, 16'd100,   1'b0);
        place_interval(8'd12,  16'd3, 16'd90,    1'b0);
        place_interval(8'd13,  16'd3, 16'd200,   1'b0);
        place_interval(8'd14,  16'd3, 16'd200,   1'b0);
        place_interval(8'd15,  16'd4, 16'd150,   1'b0);
        place_interval(8'd16,  16'd4, 16'd300,   1'b0);
        // end below start, then a repeated vreg
        place_interval(8'd17,  16'd50, 16'd40,   1'b0);
        place_interval(8'd17,  16'd50, 16'd45,   1'b1);
        // top of the position range retires everything
        place_interval(8'd18,  16'd65535, 16'd65535, 1'b0);
        place_interval(8'd18,  16'd65535, 16'd0,     1'b0);
        place_interval(8'd255, 16'd65535, 16'd65535, 1'b1);
        place_interval(8'd0,   16'd65535, 16'd65535, 1'b1);
        place_interval(8'd1,   16'd65535, 16'd65535, 1'b1);
        place_interval(8'd128, 16'd65535, 16'd65535, 1'b0);
        wait_until_drained();

        // sender mostly busy, receiver mostly stalled
        write_spill_base(8'd255);
        run_random_intervals(380);
        wait_until_drained();

        // the other way round
        write_spill_base(8'd0);
        tx_idle_pct  = 84;
        rx_idle_pct <= 21;
        run_random_intervals(380);
        wait_until_drained();

        // no idling, with one long hold-off on the result side
        write_spill_base(ADDR_W'($urandom_range(1, 254)));
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        run_random_intervals(190);
        hold_reqs <= hold_reqs + 1;
        run_random_intervals(190);
        wait_until_drained();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lsra_pkg.sv
rtl/core/lsra_in_if.sv
rtl/core/lsra_out_if.sv
rtl/core/lsra_ram.sv
rtl/core/lsra_scan.sv
rtl/core/lsra_ctrl.sv
rtl/core/linear_scan_register_allocator.sv
bench/linear_scan_register_allocator_checker.sv
bench/linear_scan_register_allocator_test.sv
